@@ rtl/fxa_pkg.sv @@
// Shared types, constants and saturation helpers for the fixed-point ALU.
package fxa_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_W = 32;
	localparam int QUO_W = 33;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_GT  = 4'd4,
		OP_LT  = 4'd5,
		OP_GE  = 4'd6,
		OP_LE  = 4'd7,
		OP_EQ  = 4'd8,
		OP_NE  = 4'd9,
		OP_MAX = 4'd10,
		OP_MIN = 4'd11,
		OP_INC = 4'd12,
		OP_DEC = 4'd13
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] res;
		status_t     status;
	} sat_t;

	// One item as it travels down the pipeline.
	typedef struct packed {
		op_t          op;
		logic         neg;
		logic [31:0]  res;
		logic         cmp;
		status_t      status;
		logic [63:0]  prod;
		logic [31:0]  mag_a;
		logic [31:0]  dvs;
		logic         dz;
		logic         ovf;
		logic [31:0]  rem;
		logic [QUO_W-1:0] quo;
	} pipe_t;

	function automatic sat_t pack_sat(input logic neg, input logic [63:0] mag);
		sat_t s;
		s.status = ST_OK;
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				s.res = 32'h8000_0000;
				s.status = ST_OVF;
			end else begin
				s.res = 32'(64'd0 - mag);
			end
		end else begin
			if (mag > 64'h7FFF_FFFF) begin
				s.res = 32'h7FFF_FFFF;
				s.status = ST_OVF;
			end else begin
				s.res = mag[31:0];
			end
		end
		return s;
	endfunction

	function automatic sat_t clamp33(input logic signed [32:0] v);
		sat_t s;
		s.status = ST_OK;
		if (v > 33'sh0_7FFF_FFFF) begin
			s.res = 32'h7FFF_FFFF;
			s.status = ST_OVF;
		end else if (v < -33'sh0_8000_0000) begin
			s.res = 32'h8000_0000;
			s.status = ST_OVF;
		end else begin
			s.res = v[31:0];
		end
		return s;
	endfunction

endpackage

@@ rtl/fxa_if.sv @@
// Valid/ready channel interfaces for ALU requests and results.
interface fxa_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         operation;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	modport source (output valid, operation, operand_a, operand_b, input ready);
	modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fxa_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result;
	logic               compare_true;
	logic [1:0]         status;
	modport source (output valid, result, compare_true, status, input ready);
	modport sink (input valid, result, compare_true, status, output ready);
endinterface

@@ rtl/fxa_front.sv @@
// Front stages: operand decode, simple operations, multiplier and divider setup.
module fxa_front #(
	parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [3:0]         operation,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               valid_s2,
	output fxa_pkg::pipe_t     pipe_s2
);
	import fxa_pkg::*;

	localparam int SH = QUO_W - FRAC_BITS;

	pipe_t       nxt;
	pipe_t       nxt2;
	pipe_t       pipe_s1;
	logic        valid_s1;
	sat_t        sat;
	logic [31:0] rem0;

	always_comb begin
		nxt = '0;
		nxt.op = op_t'(operation);
		nxt.neg = operand_a[31] ^ operand_b[31];
		nxt.mag_a = operand_a[31] ? 32'(-operand_a) : operand_a;
		nxt.dvs = operand_b[31] ? 32'(-operand_b) : operand_b;
		nxt.status = ST_OK;
		sat = '0;
		case (op_t'(operation))
			OP_ADD: sat = clamp33(33'(operand_a) + 33'(operand_b));
			OP_SUB: sat = clamp33(33'(operand_a) - 33'(operand_b));
			OP_INC: sat = clamp33(33'(operand_a) + 33'sd1);
			OP_DEC: sat = clamp33(33'(operand_a) - 33'sd1);
			OP_MAX: sat.res = (operand_a >= operand_b) ? operand_a : operand_b;
			OP_MIN: sat.res = (operand_a >= operand_b) ? operand_b : operand_a;
			OP_GT:  nxt.cmp = operand_a > operand_b;
			OP_LT:  nxt.cmp = operand_a < operand_b;
			OP_GE:  nxt.cmp = operand_a >= operand_b;
			OP_LE:  nxt.cmp = operand_a <= operand_b;
			OP_EQ:  nxt.cmp = operand_a == operand_b;
			OP_NE:  nxt.cmp = operand_a != operand_b;
			OP_DIV: begin
				nxt.dz = (operand_b == 32'sd0);
				if (operand_b == 32'sd0) sat.status = ST_DIV0;
			end
			default: sat = '0;
		endcase
		nxt.res = sat.res;
		nxt.status = sat.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) pipe_s1 <= nxt;
	end

	// The dividend's top bits start the remainder; the quotient overflows if they already reach the divisor.
	assign rem0 = 32'(pipe_s1.mag_a >> SH);

	always_comb begin
		nxt2 = pipe_s1;
		nxt2.prod = 64'(pipe_s1.mag_a) * 64'(pipe_s1.dvs);
		nxt2.rem = rem0;
		nxt2.ovf = rem0 >= pipe_s1.dvs;
		nxt2.quo = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) pipe_s2 <= nxt2;
	end
endmodule

@@ rtl/fxa_div_step.sv @@
// One restoring-division stage: develops one quotient bit per register stage.
module fxa_div_step #(
	parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF,
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  fxa_pkg::pipe_t pin,
	output logic           out_valid,
	output fxa_pkg::pipe_t pout
);
	import fxa_pkg::*;

	logic        nbit;
	logic [32:0] trial;
	logic        ge;
	pipe_t       nxt;

	// The dividend is the first magnitude shifted up by the fraction width.
	if (BIT >= FRAC_BITS) begin : g_nbit
		assign nbit = pin.mag_a[BIT-FRAC_BITS];
	end else begin : g_zero
		assign nbit = 1'b0;
	end

	assign trial = {pin.rem, nbit};
	assign ge = trial >= {1'b0, pin.dvs};

	always_comb begin
		nxt = pin;
		nxt.rem = ge ? 32'(trial - {1'b0, pin.dvs}) : trial[31:0];
		nxt.quo = {pin.quo[QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) pout <= nxt;
	end
endmodule

@@ rtl/fxa_finish.sv @@
// Final stage: rounding and saturation of product and quotient, output register.
module fxa_finish #(
	parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  fxa_pkg::pipe_t     pin,
	output logic               valid_q,
	output logic signed [31:0] result_q,
	output logic               cmp_q,
	output logic [1:0]         status_q
);
	import fxa_pkg::*;

	localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

	logic [63:0] mul_mag;
	logic [33:0] div_mag;
	sat_t        sat;

	assign mul_mag = (pin.prod + HALF) >> FRAC_BITS;
	// Round half away from zero: bump when twice the remainder reaches the divisor.
	assign div_mag = 34'(pin.quo) + 34'({pin.rem, 1'b0} >= {1'b0, pin.dvs});

	always_comb begin
		sat.res = pin.res;
		sat.status = pin.status;
		case (pin.op)
			OP_MUL: sat = pack_sat(pin.neg, mul_mag);
			OP_DIV: begin
				if (!pin.dz) begin
					sat = pack_sat(pin.neg, pin.ovf ? 64'hFFFF_FFFF_FFFF : 64'(div_mag));
				end
			end
			default: sat = sat;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= sat.res;
			cmp_q <= pin.cmp;
			status_q <= sat.status;
		end
	end
endmodule

@@ rtl/fixed_point_alu.sv @@
// Fixed-point ALU: signed 32-bit words with FRAC_BITS fraction bits. It takes one item per
// cycle unless the output is held, and passes it through two front stages (decode and simple
// operations, then the multiplier and divider setup), 33 restoring-divider stages that develop
// one quotient bit each, and a rounding and saturation stage that is also the output register.
// Every operation runs through the full pipeline, so results leave in order. When the output
// is held, the whole pipeline holds and ready drops.
module fixed_point_alu #(
	parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	fxa_req_if.sink req,
	fxa_rsp_if.source rsp
);
	import fxa_pkg::*;

	localparam int STEPS = QUO_W;

	logic  en;
	logic  valid_s2;
	pipe_t pipe_s2;
	logic  step_v [STEPS+1];
	pipe_t step_p [STEPS+1];

	assign en = !rsp.valid || rsp.ready;
	assign req.ready = en;

	fxa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(req.valid), .operation(req.operation),
		.operand_a(req.operand_a), .operand_b(req.operand_b),
		.valid_s2(valid_s2), .pipe_s2(pipe_s2)
	);

	assign step_v[0] = valid_s2;
	assign step_p[0] = pipe_s2;

	for (genvar i = 0; i < STEPS; i++) begin : g_div
		fxa_div_step #(.FRAC_BITS(FRAC_BITS), .BIT(STEPS - 1 - i)) u_step (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(step_v[i]), .pin(step_p[i]),
			.out_valid(step_v[i+1]), .pout(step_p[i+1])
		);
	end

	fxa_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(step_v[STEPS]), .pin(step_p[STEPS]),
		.valid_q(rsp.valid), .result_q(rsp.result),
		.cmp_q(rsp.compare_true), .status_q(rsp.status)
	);
endmodule

@@ rtl/fxa_chk.sv @@
// Port-level assertions for the fixed-point ALU, bound to the top level.
module fxa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] result,
	input logic        compare_true,
	input logic [1:0]  status
);
	import fxa_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result) && $stable(status))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready == (!rsp_valid || rsp_ready))
		else $error("ready does not follow output stall");

	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && compare_true |-> result == 32'd0 && status == ST_OK)
		else $error("comparison item with nonzero result or status");

	a_div0: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_DIV0 |-> result == 32'd0 && !compare_true)
		else $error("divide by zero with nonzero result");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status != 2'd3)
		else $error("undefined status code");
endmodule

bind fixed_point_alu fxa_chk u_chk (
	.clk(clk), .arst_n(arst_n), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.result(rsp.result), .compare_true(rsp.compare_true), .status(rsp.status)
);

@@ sim/fixed_point_alu_tb.sv @@
// Self-checking testbench for the fixed-point ALU with random traffic and back-pressure.
module fixed_point_alu_tb;
	import fxa_pkg::*;

	localparam int FB = FRAC_BITS_DEF;

	typedef struct {
		logic [31:0] result;
		logic        compare_true;
		logic [1:0]  status;
	} alu_out_t;

	// Signed magnitude and sign to a saturated word.
	function automatic alu_out_t saturate(input bit neg, input logic [63:0] mag);
		alu_out_t o;
		o.compare_true = 0;
		o.status = ST_OK;
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				o.result = 32'h8000_0000;
				o.status = ST_OVF;
			end else begin
				o.result = 32'(64'd0 - mag);
			end
		end else if (mag > 64'h7FFF_FFFF) begin
			o.result = 32'h7FFF_FFFF;
			o.status = ST_OVF;
		end else begin
			o.result = mag[31:0];
		end
		return o;
	endfunction

	function automatic alu_out_t sat_sum(input logic signed [63:0] v);
		logic [63:0] m;
		m = v < 0 ? 64'd0 - v : v;
		return saturate(v < 0, m);
	endfunction

	function automatic alu_out_t alu_predict(input logic [3:0] op, input logic signed [31:0] a,
			input logic signed [31:0] b);
		alu_out_t o;
		logic signed [63:0] sa, sb;
		logic [63:0] ma, mb, p, n;
		sa = a;
		sb = b;
		ma = sa < 0 ? 64'd0 - sa : sa;
		mb = sb < 0 ? 64'd0 - sb : sb;
		o.result = 0;
		o.compare_true = 0;
		o.status = ST_OK;
		case (op)
			OP_ADD: o = sat_sum(sa + sb);
			OP_SUB: o = sat_sum(sa - sb);
			OP_MUL: begin
				p = ma * mb;
				o = saturate((a < 0) != (b < 0), (p + (64'd1 << (FB - 1))) >> FB);
			end
			OP_DIV: begin
				if (b == 0) begin
					o.status = ST_DIV0;
				end else begin
					n = ma << FB;
					o = saturate((a < 0) != (b < 0), (2 * n + mb) / (2 * mb));
				end
			end
			OP_GT: o.compare_true = a > b;
			OP_LT: o.compare_true = a < b;
			OP_GE: o.compare_true = a >= b;
			OP_LE: o.compare_true = a <= b;
			OP_EQ: o.compare_true = a == b;
			OP_NE: o.compare_true = a != b;
			OP_MAX: o.result = a >= b ? a : b;
			OP_MIN: o.result = a >= b ? b : a;
			OP_INC: o = sat_sum(sa + 1);
			OP_DEC: o = sat_sum(sa - 1);
			default: ;
		endcase
		return o;
	endfunction

	class alu_scoreboard;
		alu_out_t pending[$];
		int errors = 0;

		function void note_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
			pending.push_back(alu_predict(op, a, b));
		endfunction

		function void check_result(logic [31:0] r, logic c, logic [1:0] s);
			alu_out_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", r);
				return;
			end
			e = pending.pop_front();
			if (e.result !== r || e.compare_true !== c || e.status !== s) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp %h/%b/%0d got %h/%b/%0d",
						e.result, e.compare_true, e.status, r, c, s);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	fxa_req_if req();
	fxa_rsp_if rsp();
	alu_scoreboard sb = new();

	fixed_point_alu dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		req.valid = 0;
		req.operation = 0;
		req.operand_a = 0;
		req.operand_b = 0;
		rsp.ready = 0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
			1: return 32'h8000_0000 + $urandom_range(0, 2);
			2: return $urandom_range(0, 2) - 1;
			3: return $signed($urandom_range(0, 4095)) - 2048;
			4: return $signed($urandom_range(0, 65535) << 8) >>> $urandom_range(0, 8);
			default: return $urandom;
		endcase
	endfunction

	// Present one item and hold it until it is taken.
	task automatic send_item(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
		int g;
		g = gap_len();
		if (g > 0) begin
			req.valid <= 0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1;
		req.operation <= op;
		req.operand_a <= a;
		req.operand_b <= b;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.note_request(op, a, b);
	endtask

	// Sink side: random stalls, check on every accepted result.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				sb.check_result(rsp.result, rsp.compare_true, rsp.status);
			if (g > 0) begin
				g--;
				rsp.ready <= 0;
			end else begin
				rsp.ready <= 1;
				if ($urandom_range(0, 9) == 0) g = gap_len();
			end
		end
	end

	initial begin
		logic [31:0] corners[6];
		int w;
		corners = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h100};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int op = 0; op < 16; op++)
			send_item(op[3:0], corners[op % 6], corners[(op + 2) % 6]);
		send_item(OP_DIV, 32'h100, 32'h0);
		send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_item(OP_MUL, 32'h180, 32'h1);
		send_item(OP_MUL, 32'hFFFF_FE80, 32'h1);
		send_item(OP_DIV, 32'h8000_0000, 32'h1);
		send_item(OP_DIV, 32'h1, 32'h3);
		send_item(OP_MAX, 32'h5, 32'h5);
		send_item(OP_ADD, 32'h7FFF_FFFF, 32'h1);
		send_item(OP_SUB, 32'h8000_0000, 32'h1);
		for (int i = 0; i < 900; i++)
			send_item(4'($urandom_range(0, 99) < 96 ? $urandom_range(0, 13)
				: $urandom_range(14, 15)), rand_word(), rand_word());
		req.valid <= 0;
		w = 0;
		while (sb.pending.size() != 0 && w < 20000) begin
			@(posedge clk);
			w++;
		end
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("fixed_point_alu_tb: PASS");
		end else begin
			$display("fixed_point_alu_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("fixed_point_alu_tb: FAIL");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/fxa_pkg.sv
rtl/fxa_if.sv
rtl/fxa_front.sv
rtl/fxa_div_step.sv
rtl/fxa_finish.sv
rtl/fixed_point_alu.sv
rtl/fxa_chk.sv
sim/fixed_point_alu_tb.sv
